@@ src/mab_pkg.sv @@
// shared types, constants and helpers of the moving-average band filter
package mab_pkg;

   localparam int MAX_WINDOW_DEFAULT = 256;

   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 24;
   localparam int WIN_W       = 9;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;

   // one quotient bit per divider iteration
   localparam int DIV_STEPS   = SUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   typedef enum logic [MODE_W-1:0] {
      MODE_LOW  = 2'd0,
      MODE_HIGH = 2'd1,
      MODE_BAND = 2'd2,
      MODE_SUM  = 2'd3
   } mode_type;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_WINDOW  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_WINDOW = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD        = 4'd3;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [WIN_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [SUM_W-1:0]   quotient;
      logic [WIN_W-1:0]   remainder;
   } div_rsp_type;

   // zero acts as one, anything above the ring depth acts as the depth
   function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w,
                                                    input int max_w);
      logic [WIN_W-1:0] res;
      if (w == '0) begin
         res = WIN_W'(1);
      end else if (int'(w) > max_w) begin
         res = WIN_W'(max_w);
      end else begin
         res = w;
      end
      return res;
   endfunction

endpackage

@@ src/mab_if.sv @@
// channel interfaces: sample input, result output, register writes
interface mab_req_if import mab_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mab_rsp_if import mab_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered;
   logic signed [SUM_W-1:0]    window_sum;

   modport source (output valid, output filtered, output window_sum, input ready);
   modport sink   (input valid, input filtered, input window_sum, output ready);
endinterface

interface mab_csr_if import mab_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/moving_average_band_filter.sv @@
// top level of the two-stage moving-average band filter
//
//   channel   dir   payload                          transaction when
//   req_ch    in    sample[15:0] signed              valid && ready
//   rsp_ch    out   filtered[15:0], window_sum[23:0] valid && ready
//   csr_ch    in    index[3:0], data[8:0]            valid && ready (ready tied high)
//
// one sample at a time: low and high pass each take one pass of the 24-step
// iterative divider, band pass takes two and sum mode none; under hold the high
// stage skips its ring update; a new sample waits until the last one is presented
// a position wrap after a window was shrunk costs one extra divider pass
// after reset a clearing pass writes zero to every slot of both rings,
// during which no sample is taken; register writes are taken at any time
// the result register lets the next sample in while a result waits on rsp_ch
module moving_average_band_filter import mab_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mab_req_if.sink    req_ch,
   mab_rsp_if.source  rsp_ch,
   mab_csr_if.sink    csr_ch
);

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   // wide enough for position + 1 and for a window value
   localparam int PW = (AW + 1 > WIN_W) ? AW + 1 : WIN_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_POS, S_MOD, S_READ, S_SUM, S_DIV, S_OUT
   } state_type;

   // configuration registers
   mode_type         mode_ff;
   logic [WIN_W-1:0] low_window_ff;
   logic [WIN_W-1:0] high_window_ff;
   logic             hold_ff;

   // sequencer and stage state
   state_type                  state_ff;
   logic [AW-1:0]              clr_ff;
   logic                       sel_ff;     // 0 low stage, 1 high stage
   logic signed [SAMPLE_W-1:0] x_ff;       // value the current stage takes
   logic [AW-1:0]              p_ff;       // ring slot being updated
   logic                       neg_ff;     // sign of the running division
   logic [SAMPLE_W-1:0]        f_ff;
   logic [AW-1:0]              lpos_ff;
   logic [AW-1:0]              hpos_ff;
   logic signed [SUM_W-1:0]    lsum_ff;
   logic signed [SUM_W-1:0]    hsum_ff;

   // result register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff;
   logic signed [SUM_W-1:0]    rsp_sum_ff;

   // ring memories
   logic                l_wr_en, h_wr_en, l_rd_en, h_rd_en;
   logic [AW-1:0]       wr_addr;
   logic [SAMPLE_W-1:0] wr_data;
   logic [SAMPLE_W-1:0] l_rd_data, h_rd_data;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        div_neg;

   logic [WIN_W-1:0]        eff_low, eff_high, w_cur;
   logic [AW-1:0]           pos_cur, pos_fast;
   logic [PW-1:0]           pos_inc, w_ext;
   logic signed [SUM_W-1:0] sum_cur, sum_new, old_ext;
   logic [SUM_W-1:0]        sum_mag, hsum_mag, q_signed;
   logic [SAMPLE_W-1:0]     q16, hp_result;
   logic                    req_acc, rsp_load, low_only;

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign low_only = !sel_ff && (mode_ff == MODE_SUM);

   // stage arithmetic: position advance, running sum, signed quotient
   always_comb begin
      eff_low  = eff_window(low_window_ff, MAX_WINDOW);
      eff_high = eff_window(high_window_ff, MAX_WINDOW);
      w_cur    = sel_ff ? eff_high : eff_low;
      pos_cur  = sel_ff ? hpos_ff : lpos_ff;
      pos_inc  = PW'(pos_cur) + PW'(1);
      w_ext    = PW'(w_cur);
      // wrap to zero at the window end; beyond it needs a full modulo
      pos_fast = (pos_inc == w_ext) ? '0 : AW'(pos_inc);

      sum_cur  = sel_ff ? hsum_ff : lsum_ff;
      old_ext  = SUM_W'(signed'(sel_ff ? h_rd_data : l_rd_data));
      sum_new  = sum_cur + SUM_W'(x_ff) - old_ext;
      sum_mag  = sum_new[SUM_W-1] ? $unsigned(-sum_new) : $unsigned(sum_new);
      hsum_mag = hsum_ff[SUM_W-1] ? $unsigned(-hsum_ff) : $unsigned(hsum_ff);

      q_signed  = neg_ff ? (~div_rsp.quotient + SUM_W'(1)) : div_rsp.quotient;
      q16       = q_signed[SAMPLE_W-1:0];
      hp_result = x_ff - q16;
   end

   // divider requests
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = sum_mag;
      div_req.divisor  = w_cur;
      div_neg          = sum_new[SUM_W-1];
      case (state_ff)
         S_IDLE: begin
            // high pass under hold: only the frozen sum is divided
            if (req_acc && mode_ff == MODE_HIGH && hold_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = hsum_mag;
               div_req.divisor  = eff_high;
               div_neg          = hsum_ff[SUM_W-1];
            end
         end
         S_POS: begin
            if (pos_inc > w_ext) begin
               div_req.start    = 1'b1;
               div_req.dividend = SUM_W'(pos_inc);
               div_neg          = 1'b0;
            end
         end
         S_SUM: begin
            div_req.start = !low_only;
         end
         S_DIV: begin
            // band pass under hold: low result done, go straight to frozen sum
            if (div_rsp.done && !sel_ff && mode_ff == MODE_BAND && hold_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = hsum_mag;
               div_req.divisor  = eff_high;
               div_neg          = hsum_ff[SUM_W-1];
            end
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   // register writes, taken at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_LOW;
         low_window_ff  <= WIN_W'(256);
         high_window_ff <= WIN_W'(256);
         hold_ff        <= 1'b0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            REG_MODE:        mode_ff        <= mode_type'(csr_ch.data[MODE_W-1:0]);
            REG_LOW_WINDOW:  low_window_ff  <= csr_ch.data[WIN_W-1:0];
            REG_HIGH_WINDOW: high_window_ff <= csr_ch.data[WIN_W-1:0];
            REG_HOLD:        hold_ff        <= csr_ch.data[0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // sequencer: clear, position, read, update, divide, present
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sel_ff       <= 1'b0;
         lpos_ff      <= '0;
         hpos_ff      <= '0;
         lsum_ff      <= '0;
         hsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register: filled from S_OUT, emptied by a rsp transaction
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (div_req.start) begin
            neg_ff <= div_neg;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MAX_WINDOW - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  x_ff <= req_ch.sample;
                  if (mode_ff == MODE_HIGH) begin
                     sel_ff   <= 1'b1;
                     state_ff <= hold_ff ? S_DIV : S_POS;
                  end else begin
                     sel_ff   <= 1'b0;
                     state_ff <= S_POS;
                  end
               end
            end
            S_POS: begin
               if (pos_inc <= w_ext) begin
                  p_ff     <= pos_fast;
                  state_ff <= S_READ;
               end else begin
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               if (div_rsp.done) begin
                  p_ff     <= AW'(div_rsp.remainder);
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (sel_ff) begin
                  hpos_ff <= p_ff;
                  hsum_ff <= sum_new;
               end else begin
                  lpos_ff <= p_ff;
                  lsum_ff <= sum_new;
               end
               if (low_only) begin
                  f_ff     <= sum_new[SAMPLE_W-1:0];
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  if (sel_ff) begin
                     f_ff     <= hp_result;
                     state_ff <= S_OUT;
                  end else if (mode_ff == MODE_BAND) begin
                     // low-pass result becomes the high stage's input
                     x_ff     <= q16;
                     sel_ff   <= 1'b1;
                     state_ff <= hold_ff ? S_DIV : S_POS;
                  end else begin
                     f_ff     <= q16;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_filtered_ff <= f_ff;
                  rsp_sum_ff      <= (mode_ff == MODE_HIGH) ? hsum_ff : lsum_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // ring port steering: clearing pass or the active stage
   always_comb begin
      l_rd_en = (state_ff == S_READ) && !sel_ff;
      h_rd_en = (state_ff == S_READ) && sel_ff;
      if (state_ff == S_CLEAR) begin
         l_wr_en = 1'b1;
         h_wr_en = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         l_wr_en = (state_ff == S_SUM) && !sel_ff;
         h_wr_en = (state_ff == S_SUM) && sel_ff;
         wr_addr = p_ff;
         wr_data = x_ff;
      end
   end

   mab_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_low_ring (
      .clock   (clock),
      .wr_en   (l_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (l_rd_en),
      .rd_addr (p_ff),
      .rd_data (l_rd_data)
   );

   mab_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_high_ring (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (p_ff),
      .rd_data (h_rd_data)
   );

   mab_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.filtered   = rsp_filtered_ff;
   assign rsp_ch.window_sum = rsp_sum_ff;

   // divider is never restarted while a division is still running
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV || state_ff == S_MOD) && !div_rsp.done) |-> !div_req.start)
      else $error("divider restarted mid-division");

   // after a take the stage position lies inside its window
   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=>
         (PW'(sel_ff ? hpos_ff : lpos_ff) < PW'(sel_ff ? eff_high : eff_low)))
      else $error("stage position outside window");

   // one transaction in flight: no sample taken right after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ch.ready)
      else $error("second sample accepted while busy");

endmodule

@@ src/mab_ram.sv @@
// generic single-write, single-read ram with registered read data
module mab_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mab_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module mab_div import mab_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [WIN_W-1:0]     rem_ff;
   logic [WIN_W-1:0]     dsr_ff;

   logic [WIN_W:0]       shifted;
   logic                 fits;
   logic [SUM_W-1:0]     quo_in;
   logic [WIN_W-1:0]     rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      quo_in  = {quo_ff[SUM_W-2:0], fits};
      rem_in  = fits ? WIN_W'(shifted - {1'b0, dsr_ff}) : shifted[WIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            quo_ff   <= div_req.dividend;
            rem_ff   <= '0;
            dsr_ff   <= div_req.divisor;
         end else if (busy_ff) begin
            quo_ff   <= quo_in;
            rem_ff   <= rem_in;
            count_ff <= count_ff + DIV_CNT_W'(1);
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
